### rtl/pga_pkg.sv
// ----------------------------------------------------------------------------
// pga_pkg: shared types and constants for the pixel gradient angle block
// Window queue entry, back-end states, register indexes and the arctangent
// table used by the CORDIC unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pga_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DIM_W  = 11;   // configured width/height register
    localparam int POS_W  = 10;   // column/row position
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 10;   // signed diagonal difference
    localparam int MAG_W  = 13;
    localparam int ANG_W  = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // CORDIC datapath
    localparam int CRD_W  = 28;
    localparam int SQ_W   = 20;   // gx^2 + gy^2
    localparam int RT_W   = 14;   // root of 256 * (gx^2 + gy^2)
    localparam int REM_W  = 17;
    localparam int ISQ_STEPS = 14;
    localparam int CRD_STEPS = 16;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_GRAD_THRESH  = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    // one 2x2 window on its way from front to back
    typedef struct packed {
        logic [POS_W-1:0]         col;
        logic [POS_W-1:0]         row;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     flast;
    } t_win;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_RUN  = 2'd1,
        BK_DONE = 2'd2
    } t_bstate;

    // round(atan(2^-i) / (2*pi) * 65536)
    function automatic logic [ANG_W-1:0] atan_turn(input logic [3:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 16'd8192;
            4'd1:    v = 16'd4836;
            4'd2:    v = 16'd2555;
            4'd3:    v = 16'd1297;
            4'd4:    v = 16'd651;
            4'd5:    v = 16'd326;
            4'd6:    v = 16'd163;
            4'd7:    v = 16'd81;
            4'd8:    v = 16'd41;
            4'd9:    v = 16'd20;
            4'd10:   v = 16'd10;
            4'd11:   v = 16'd5;
            4'd12:   v = 16'd3;
            4'd13:   v = 16'd1;
            4'd14:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/pixel_gradient_angle.sv
// ----------------------------------------------------------------------------
// pixel_gradient_angle: 2x2 gradient magnitude and orientation
// Line-buffered window former feeding an iterative magnitude/angle unit
// through a four-entry window queue.
//
//   channel   direction  handshake              payload
//   pixel in  input      i_push / o_full        i_pixel
//   result    output     o_empty / i_pop        o_col .. o_frame_last
//   config    input      i_cfg_we               i_cfg_addr, i_cfg_data
//
// A pixel is taken while i_push is high and o_full low; the back unit
// loads, runs 16 CORDIC steps and writes out one window before the next.
// Row 0 or column 0 pixels form no window, passing one per cycle unless full.
// Reset is synchronous, active low; the line buffer is not cleared.
// Either side may stall; the queue and result register decouple them.
// ----------------------------------------------------------------------------
`default_nettype none
module pixel_gradient_angle (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    output logic                       o_full,
    input  wire [pga_pkg::PIX_W-1:0]   i_pixel,
    output logic                       o_empty,
    input  wire                        i_pop,
    output logic [pga_pkg::POS_W-1:0]  o_col,
    output logic [pga_pkg::POS_W-1:0]  o_row,
    output logic [pga_pkg::MAG_W-1:0]  o_magnitude,
    output logic [pga_pkg::ANG_W-1:0]  o_angle,
    output logic                       o_angle_valid,
    output logic [pga_pkg::MAG_W-1:0]  o_max_magnitude,
    output logic                       o_frame_last,
    input  wire                        i_cfg_we,
    input  wire [1:0]                  i_cfg_addr,
    input  wire [pga_pkg::MAG_W-1:0]   i_cfg_data
);
    import pga_pkg::*;

    logic [DIM_W-1:0]   r_frame_width;
    logic [DIM_W-1:0]   r_frame_height;
    logic [MAG_W-1:0]   r_threshold;

    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    logic [Q_CNT_W-1:0] q_count;
    t_win               q_wdata;
    t_win               q_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(640);
            r_frame_height <= DIM_W'(480);
            r_threshold    <= MAG_W'(84);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                REG_GRAD_THRESH:  r_threshold    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pga_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_pixel        (i_pixel),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_count      (q_count),
        .o_full         (o_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    pga_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    pga_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_data        (q_rdata),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .i_threshold     (r_threshold),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_col           (o_col),
        .o_row           (o_row),
        .o_magnitude     (o_magnitude),
        .o_angle         (o_angle),
        .o_angle_valid   (o_angle_valid),
        .o_max_magnitude (o_max_magnitude),
        .o_frame_last    (o_frame_last)
    );

    // queue never overflows or underflows
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push && !q_pop |-> q_count < Q_CNT_W'(Q_DEPTH))
        else $error("window queue overflow");

    a_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("window queue underflow");

    // a defined magnitude never exceeds the reported frame maximum
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_angle_valid |-> o_max_magnitude >= o_magnitude)
        else $error("frame maximum below defined magnitude");

    // nothing waits on the result side right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result present after reset");

endmodule
`default_nettype wire

### rtl/pga_fifo.sv
// ----------------------------------------------------------------------------
// pga_fifo: window queue between front and back
// Small register queue; reports its fill level so the front can hold off.
// ----------------------------------------------------------------------------
`default_nettype none
module pga_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  pga_pkg::t_win        i_data,
    input  wire                  i_pop,
    output pga_pkg::t_win        o_data,
    output logic                 o_empty,
    output logic [pga_pkg::Q_CNT_W-1:0] o_count
);
    import pga_pkg::*;

    t_win               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule
`default_nettype wire

### rtl/pga_front.sv
// ----------------------------------------------------------------------------
// pga_front: pixel intake, line buffer and window forming
// Tracks raster position, reads the upper row from the line buffer and
// forms the diagonal differences of each complete 2x2 window.
// ----------------------------------------------------------------------------
`default_nettype none
module pga_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_push,
    input  wire [pga_pkg::PIX_W-1:0]      i_pixel,
    input  wire [pga_pkg::DIM_W-1:0]      i_frame_width,
    input  wire [pga_pkg::DIM_W-1:0]      i_frame_height,
    input  wire [pga_pkg::Q_CNT_W-1:0]    i_q_count,
    output logic                          o_full,
    output logic                          o_q_push,
    output pga_pkg::t_win                 o_q_data
);
    import pga_pkg::*;

    localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MaxH = DIM_W'(MAX_HEIGHT);

    logic [PIX_W-1:0] r_line [MAX_WIDTH];

    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic             r_s1_valid;
    logic             r_s1_emit;
    logic             r_s1_flast;
    logic [POS_W-1:0] r_s1_col;
    logic [POS_W-1:0] r_s1_row;
    logic [PIX_W-1:0] r_s1_pix;
    logic [PIX_W-1:0] r_s1_up;
    logic [PIX_W-1:0] r_left;
    logic [PIX_W-1:0] r_upleft;

    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;
    logic             accept;
    logic             last_col;
    logic             last_row;
    logic signed [GRAD_W-1:0] da;
    logic signed [GRAD_W-1:0] bc;

    // clamp the frame size to the supported range
    always_comb begin
        if (i_frame_width < DIM_W'(2))       w_clamp = DIM_W'(2);
        else if (i_frame_width > MaxW)       w_clamp = MaxW;
        else                                 w_clamp = i_frame_width;
        if (i_frame_height < DIM_W'(2))      h_clamp = DIM_W'(2);
        else if (i_frame_height > MaxH)      h_clamp = MaxH;
        else                                 h_clamp = i_frame_height;
    end

    // hold off unless the queue can take everything in flight
    assign o_full   = ({1'b0, i_q_count} + {{Q_CNT_W{1'b0}}, r_s1_valid})
                      >= (Q_CNT_W+1)'(Q_DEPTH);
    assign accept   = i_push && !o_full;
    assign last_col = {1'b0, r_col} >= (w_clamp - 1'b1);
    assign last_row = {1'b0, r_row} >= (h_clamp - 1'b1);

    // line buffer: read the old entry, then overwrite with this pixel
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_up      <= r_line[r_col];
            r_line[r_col] <= i_pixel;
        end
    end

    // stage 0: raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= (r_col != '0) && (r_row != '0);
            r_s1_flast <= last_col && last_row;
            r_s1_col   <= r_col - 1'b1;
            r_s1_row   <= r_row - 1'b1;
            r_s1_pix   <= i_pixel;
        end
    end

    // window neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (r_s1_valid) begin
            r_left   <= r_s1_pix;
            r_upleft <= r_s1_up;
        end
    end

    // diagonal differences
    assign da = $signed({2'b00, r_s1_pix}) - $signed({2'b00, r_upleft});
    assign bc = $signed({2'b00, r_s1_up})  - $signed({2'b00, r_left});

    assign o_q_push       = r_s1_valid && r_s1_emit;
    assign o_q_data.col   = r_s1_col;
    assign o_q_data.row   = r_s1_row;
    assign o_q_data.gx    = da + bc;
    assign o_q_data.gy    = da - bc;
    assign o_q_data.flast = r_s1_flast;

endmodule
`default_nettype wire

### rtl/pga_back.sv
// ----------------------------------------------------------------------------
// pga_back: magnitude and orientation unit
// Runs a 2-bit-per-step square root and a 16-step vectoring CORDIC side by
// side, then applies the threshold and frame maximum into the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module pga_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  pga_pkg::t_win              i_q_data,
    input  wire                        i_q_empty,
    output logic                       o_q_pop,
    input  wire [pga_pkg::MAG_W-1:0]   i_threshold,
    input  wire                        i_pop,
    output logic                       o_empty,
    output logic [pga_pkg::POS_W-1:0]  o_col,
    output logic [pga_pkg::POS_W-1:0]  o_row,
    output logic [pga_pkg::MAG_W-1:0]  o_magnitude,
    output logic [pga_pkg::ANG_W-1:0]  o_angle,
    output logic                       o_angle_valid,
    output logic [pga_pkg::MAG_W-1:0]  o_max_magnitude,
    output logic                       o_frame_last
);
    import pga_pkg::*;

    t_bstate r_state, n_state;

    logic [3:0]               r_cnt;
    logic signed [CRD_W-1:0]  r_x;
    logic signed [CRD_W-1:0]  r_y;
    logic [ANG_W-1:0]         r_acc;
    logic [2*RT_W-1:0]        r_v;
    logic [REM_W-1:0]         r_rem;
    logic [RT_W-1:0]          r_root;
    logic [POS_W-1:0]         r_col;
    logic [POS_W-1:0]         r_row;
    logic                     r_flast;
    logic [MAG_W-1:0]         r_runmax;
    logic                     r_out_valid;

    logic                     load;
    logic                     finish;
    logic signed [GRAD_W:0]   x0;
    logic signed [GRAD_W:0]   y0;
    logic signed [GRAD_W:0]   xf;
    logic signed [GRAD_W:0]   yf;
    logic [SQ_W-1:0]          sumsq;
    logic signed [CRD_W-1:0]  xs;
    logic signed [CRD_W-1:0]  ys;
    logic [REM_W-1:0]         rem2;
    logic [REM_W-1:0]         trial;
    logic [RT_W:0]            root_inc;
    logic [MAG_W-1:0]         mag;
    logic                     valid;
    logic [MAG_W-1:0]         newmax;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and queue pop
    always_comb begin
        n_state = r_state;
        load    = 1'b0;
        finish  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    load    = 1'b1;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (r_cnt == 4'(CRD_STEPS-1)) n_state = BK_DONE;
            end
            BK_DONE: begin
                if (!r_out_valid || i_pop) begin
                    finish  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end
    assign o_q_pop = load;

    // fold the vector (-gy, gx) into the right half plane
    always_comb begin
        x0 = -$signed({i_q_data.gy[GRAD_W-1], i_q_data.gy});
        y0 = $signed({i_q_data.gx[GRAD_W-1], i_q_data.gx});
        if (x0 < 0) begin
            xf = -x0;
            yf = -y0;
        end else begin
            xf = x0;
            yf = y0;
        end
        sumsq = SQ_W'(i_q_data.gx * i_q_data.gx) + SQ_W'(i_q_data.gy * i_q_data.gy);
    end

    // one CORDIC step and one root step
    always_comb begin
        xs       = r_x >>> r_cnt;
        ys       = r_y >>> r_cnt;
        rem2     = {r_rem[REM_W-3:0], r_v[2*RT_W-1 -: 2]};
        trial    = {1'b0, r_root, 2'b01};
        root_inc = {1'b0, r_root} + 1'b1;
        mag      = root_inc[MAG_W:1];
        valid    = mag > i_threshold;
        newmax   = (valid && mag > r_runmax) ? mag : r_runmax;
    end

    // iterative datapath
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cnt   <= '0;
            r_x     <= CRD_W'(xf) <<< 14;
            r_y     <= CRD_W'(yf) <<< 14;
            r_acc   <= (x0 < 0) ? ANG_W'(32768) : '0;
            r_v     <= {sumsq, 8'd0};
            r_rem   <= '0;
            r_root  <= '0;
            r_col   <= i_q_data.col;
            r_row   <= i_q_data.row;
            r_flast <= i_q_data.flast;
        end else if (r_state == BK_RUN) begin
            r_cnt <= r_cnt + 1'b1;
            if (!r_y[CRD_W-1] && r_y != '0) begin
                r_x   <= r_x + ys;
                r_y   <= r_y - xs;
                r_acc <= r_acc + atan_turn(r_cnt);
            end else begin
                r_x   <= r_x - ys;
                r_y   <= r_y + xs;
                r_acc <= r_acc - atan_turn(r_cnt);
            end
            if (r_cnt < 4'(ISQ_STEPS)) begin
                r_v <= r_v << 2;
                if (rem2 >= trial) begin
                    r_rem  <= rem2 - trial;
                    r_root <= {r_root[RT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem2;
                    r_root <= {r_root[RT_W-2:0], 1'b0};
                end
            end
        end
    end

    // result register and frame maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_runmax    <= '0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
            r_runmax    <= r_flast ? '0 : newmax;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            o_col           <= r_col;
            o_row           <= r_row;
            o_magnitude     <= mag;
            o_angle         <= r_acc;
            o_angle_valid   <= valid;
            o_max_magnitude <= newmax;
            o_frame_last    <= r_flast;
        end
    end

    assign o_empty = !r_out_valid;

endmodule
`default_nettype wire
